@@ hdl/tpet_pkg.sv @@
// Shared types, codes and defaults of the timeout expiry table.
`default_nettype none
package tpet_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;

  typedef enum logic [1:0] {
    KIND_ADD_ONCE   = 2'd0,
    KIND_ADD_REPEAT = 2'd1,
    KIND_ERASE      = 2'd2,
    KIND_RUN        = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_ERASED    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_SUMMARY   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERASE,
    S_DUE,
    S_FIND,
    S_PUT,
    S_UPD,
    S_RESP
  } fsm_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] now;
    logic [31:0] delay_or_interval;
    logic [31:0] target_id;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] entry_id;
    logic        has_next;
    logic [31:0] next_expiration;
    logic        last;
  } out_res_t;

endpackage
`default_nettype wire

@@ hdl/tpet_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tpet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/timeout_pool_expiry_table_unit.sv @@
// Top level of the timeout expiry table: slot RAM, sweep sequencer and result register.
//
//   channel | dir | ports                          | payload
//   in      | in  | in_valid, in_ready, in_data    | in_req_t
//   out     | out | out_valid, out_ready, out_data | out_res_t
//
// Add registers its result directly from idle. Erase sweeps the slot RAM once.
// Run sweeps once to mark due entries, once per expired entry plus one empty
// pass to pick the earliest, and once to reschedule and find the next expiration.
// Synchronous reset clears the valid bits, the id counter and the sequencer.
// A stalled result holds the sequencer where it emits a result; no new request is taken until it is free.
`default_nettype none
module timeout_pool_expiry_table_unit
  import tpet_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_res_t      out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 32 + 2 * TIME_BITS + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] SCAN_END = CW'(CAPACITY);

  fsm_t                 state_r, state_nxt;
  in_req_t              req_r, req_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic [IW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [CAPACITY-1:0]  valid_r, valid_nxt;
  logic [CAPACITY-1:0]  due_r, due_nxt;
  logic [CAPACITY-1:0]  pend_r, pend_nxt;
  logic                 found_r, found_nxt;
  logic                 best_v_r, best_v_nxt;
  logic [TIME_BITS-1:0] best_exp_r, best_exp_nxt;
  logic [31:0]          best_id_r, best_id_nxt;
  logic [IW-1:0]        best_idx_r, best_idx_nxt;
  logic [31:0]          idc_r, idc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_res_t             out_data_r, out_data_nxt;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [EW-1:0]        ram_rdata;

  logic [31:0]          rd_id;
  logic [TIME_BITS-1:0] rd_exp;
  logic                 rd_rep;
  logic [TIME_BITS-1:0] rd_intv;

  logic [TIME_BITS-1:0] req_now, in_now, in_dly, add_dly, add_exp, upd_exp;
  logic [IW-1:0]        free_idx;
  logic                 free_v;
  logic                 out_free, scan_done, upd_live;
  logic [TIME_BITS-1:0] upd_eff;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  tpet_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_id   = ram_rdata[EW-1 -: 32];
  assign rd_exp  = ram_rdata[2*TIME_BITS : TIME_BITS+1];
  assign rd_rep  = ram_rdata[TIME_BITS];
  assign rd_intv = ram_rdata[TIME_BITS-1:0];

  assign in_now  = TIME_BITS'(in_data.now);
  assign in_dly  = TIME_BITS'(in_data.delay_or_interval);
  assign add_dly = (in_data.kind == KIND_ADD_REPEAT && in_dly == '0) ?
                   TIME_BITS'(1) : in_dly;
  assign add_exp = sat_add(in_now, add_dly);
  assign req_now = TIME_BITS'(req_r.now);
  assign upd_exp = sat_add(req_now, rd_intv);

  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_v   = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign scan_done = rd_v_r && (rd_idx_r == LAST_IDX);
  assign upd_live  = valid_r[rd_idx_r] && !(due_r[rd_idx_r] && !rd_rep);
  assign upd_eff   = due_r[rd_idx_r] ? upd_exp : rd_exp;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    scan_nxt      = scan_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    valid_nxt     = valid_r;
    due_nxt       = due_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    best_v_nxt    = best_v_r;
    best_exp_nxt  = best_exp_r;
    best_id_nxt   = best_id_r;
    best_idx_nxt  = best_idx_r;
    idc_nxt       = idc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = rd_idx_r;
    ram_wdata     = {rd_id, upd_exp, rd_rep, rd_intv};

    if (state_r != S_IDLE && state_r != S_PUT && state_r != S_RESP &&
        scan_r != SCAN_END) begin
      rd_v_nxt   = 1'b1;
      rd_idx_nxt = scan_r[IW-1:0];
      scan_nxt   = scan_r + CW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt    = in_data;
          scan_nxt   = '0;
          found_nxt  = 1'b0;
          best_v_nxt = 1'b0;
          case (in_data.kind)
            KIND_ADD_ONCE, KIND_ADD_REPEAT: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_data_nxt.last = 1'b1;
              if (free_v) begin
                ram_we    = 1'b1;
                ram_waddr = free_idx;
                ram_wdata = {idc_r, add_exp, in_data.kind == KIND_ADD_REPEAT, add_dly};
                valid_nxt[free_idx] = 1'b1;
                out_data_nxt.status   = ST_ADDED;
                out_data_nxt.entry_id = idc_r;
                idc_nxt = idc_r + 32'd1;
              end else begin
                out_data_nxt.status = ST_FULL;
              end
            end
            KIND_ERASE: state_nxt = S_ERASE;
            default:    state_nxt = S_DUE;
          endcase
        end
      end
      S_ERASE: begin
        if (rd_v_r && valid_r[rd_idx_r] && rd_id == req_r.target_id) begin
          valid_nxt[rd_idx_r] = 1'b0;
          found_nxt = 1'b1;
        end
        if (scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_DUE: begin
        if (rd_v_r) begin
          due_nxt[rd_idx_r]  = valid_r[rd_idx_r] && rd_exp <= req_now;
          pend_nxt[rd_idx_r] = valid_r[rd_idx_r] && rd_exp <= req_now;
        end
        if (scan_done) begin
          state_nxt = S_FIND;
          scan_nxt  = '0;
        end
      end
      S_FIND: begin
        if (rd_v_r && pend_r[rd_idx_r] &&
            (!best_v_r || rd_exp < best_exp_r ||
             (rd_exp == best_exp_r && rd_id < best_id_r))) begin
          best_v_nxt   = 1'b1;
          best_exp_nxt = rd_exp;
          best_id_nxt  = rd_id;
          best_idx_nxt = rd_idx_r;
        end
        if (scan_done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        scan_nxt = '0;
        if (!best_v_r) begin
          state_nxt = S_UPD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.status   = ST_EXPIRED;
          out_data_nxt.entry_id = best_id_r;
          pend_nxt[best_idx_r]  = 1'b0;
          best_v_nxt = 1'b0;
          state_nxt  = S_FIND;
        end
      end
      S_UPD: begin
        if (rd_v_r) begin
          if (due_r[rd_idx_r]) begin
            if (rd_rep) begin
              ram_we = 1'b1;
            end else begin
              valid_nxt[rd_idx_r] = 1'b0;
            end
          end
          if (upd_live && (!best_v_r || upd_eff < best_exp_r)) begin
            best_v_nxt   = 1'b1;
            best_exp_nxt = upd_eff;
          end
        end
        if (scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.last = 1'b1;
          if (req_r.kind == KIND_ERASE) begin
            out_data_nxt.status   = found_r ? ST_ERASED : ST_NOT_FOUND;
            out_data_nxt.entry_id = req_r.target_id;
          end else begin
            out_data_nxt.status   = ST_SUMMARY;
            out_data_nxt.has_next = best_v_r;
            out_data_nxt.next_expiration = best_v_r ? 32'(best_exp_r) : 32'd0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      valid_r     <= '0;
      idc_r       <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      valid_r     <= valid_nxt;
      idc_r       <= idc_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rd_idx_r   <= rd_idx_nxt;
    due_r      <= due_nxt;
    pend_r     <= pend_nxt;
    found_r    <= found_nxt;
    best_v_r   <= best_v_nxt;
    best_exp_r <= best_exp_nxt;
    best_id_r  <= best_id_nxt;
    best_idx_r <= best_idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

@@ test/timeout_pool_expiry_table_checker.sv @@
// Checker of the timeout expiry table: predicts results of each request and compares them.
`timescale 1ns / 100ps
`default_nettype none
module timeout_pool_expiry_table_checker
  import tpet_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_ready,
  input  wire in_req_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_ready,
  input  wire out_res_t out_data,
  output int            fail_count,
  output int            pending_count,
  output int            expired_seen,
  output int            full_seen
);

  localparam int NSLOT = CAPACITY_DEF;

  logic        tbl_valid[NSLOT];
  logic [31:0] tbl_id[NSLOT];
  logic [31:0] tbl_exp[NSLOT];
  logic        tbl_rep[NSLOT];
  logic [31:0] tbl_ivl[NSLOT];
  logic [31:0] next_id;
  out_res_t    awaited_results[$];

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic out_res_t make_res(status_t st, logic [31:0] id, logic hn,
                                        logic [31:0] nx, logic lst);
    out_res_t r;
    r.status = st;
    r.entry_id = id;
    r.has_next = hn;
    r.next_expiration = nx;
    r.last = lst;
    return r;
  endfunction

  task automatic apply_request(in_req_t req);
    int          free_slot;
    int          best;
    logic        due[NSLOT];
    logic        pend[NSLOT];
    logic        has;
    logic [31:0] nx;
    logic [31:0] dly;
    free_slot = -1;
    has = 1'b0;
    nx = '0;
    dly = req.delay_or_interval;
    case (req.kind)
      KIND_ADD_ONCE, KIND_ADD_REPEAT: begin
        for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          awaited_results.push_back(make_res(ST_FULL, '0, 1'b0, '0, 1'b1));
        end else begin
          if (req.kind == KIND_ADD_REPEAT && dly == 0) dly = 1;
          tbl_valid[free_slot] = 1'b1;
          tbl_id[free_slot] = next_id;
          tbl_exp[free_slot] = sat_sum(req.now, dly);
          tbl_rep[free_slot] = (req.kind == KIND_ADD_REPEAT);
          tbl_ivl[free_slot] = dly;
          awaited_results.push_back(make_res(ST_ADDED, next_id, 1'b0, '0, 1'b1));
          next_id = next_id + 1;
        end
      end
      KIND_ERASE: begin
        has = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_valid[i] && tbl_id[i] == req.target_id) begin
            tbl_valid[i] = 1'b0;
            has = 1'b1;
          end
        end
        awaited_results.push_back(make_res(has ? ST_ERASED : ST_NOT_FOUND,
                                           req.target_id, 1'b0, '0, 1'b1));
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          due[i] = tbl_valid[i] && tbl_exp[i] <= req.now;
          pend[i] = due[i];
        end
        forever begin
          best = -1;
          for (int i = 0; i < NSLOT; i++) begin
            if (pend[i] && (best < 0 || tbl_exp[i] < tbl_exp[best] ||
                (tbl_exp[i] == tbl_exp[best] && tbl_id[i] < tbl_id[best])))
              best = i;
          end
          if (best < 0) break;
          pend[best] = 1'b0;
          awaited_results.push_back(make_res(ST_EXPIRED, tbl_id[best], 1'b0, '0, 1'b0));
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (due[i]) begin
            if (tbl_rep[i]) tbl_exp[i] = sat_sum(req.now, tbl_ivl[i]);
            else tbl_valid[i] = 1'b0;
          end
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_valid[i] && (!has || tbl_exp[i] < nx)) begin
            nx = tbl_exp[i];
            has = 1'b1;
          end
        end
        awaited_results.push_back(make_res(ST_SUMMARY, '0, has, has ? nx : '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_res_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
      next_id = '0;
      awaited_results.delete();
      fail_count = 0;
      expired_seen = 0;
      full_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result status=%0d id=%0d", out_data.status, out_data.entry_id);
          fail_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_data.status == ST_EXPIRED) expired_seen++;
          if (out_data.status == ST_FULL) full_seen++;
          if (out_data.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_data.status);
            fail_count++;
          end
          if (out_data.entry_id !== exp_r.entry_id) begin
            $error("entry_id: expected %0d, actual %0d", exp_r.entry_id, out_data.entry_id);
            fail_count++;
          end
          if (out_data.has_next !== exp_r.has_next) begin
            $error("has_next: expected %0d, actual %0d", exp_r.has_next, out_data.has_next);
            fail_count++;
          end
          if (out_data.next_expiration !== exp_r.next_expiration) begin
            $error("next_expiration: expected %0d, actual %0d",
                   exp_r.next_expiration, out_data.next_expiration);
            fail_count++;
          end
          if (out_data.last !== exp_r.last) begin
            $error("last: expected %0d, actual %0d", exp_r.last, out_data.last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) apply_request(in_data);
    end
    pending_count = awaited_results.size();
  end

endmodule
`default_nettype wire

@@ test/timeout_pool_expiry_table_unit_tb.sv @@
// Testbench top of the timeout expiry table: request stimulus, stalls and verdict.
`timescale 1ns / 100ps
`default_nettype none
module timeout_pool_expiry_table_unit_tb;
  import tpet_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_res_t out_data;
  int       fail_count;
  int       pending_count;
  int       expired_seen;
  int       full_seen;
  int       req_count;
  int       idle_cycles;
  logic     quiet_phase;
  logic [31:0] clock_now;
  logic [31:0] base_id;

  timeout_pool_expiry_table_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  timeout_pool_expiry_table_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .expired_seen(expired_seen), .full_seen(full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(kind_t k, logic [31:0] t, logic [31:0] d, logic [31:0] id);
    in_req_t req;
    req.kind = k;
    req.now = t;
    req.delay_or_interval = d;
    req.target_id = id;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    req_count++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic send_random;
    int     sel;
    kind_t  k;
    logic [31:0] d;
    sel = $urandom_range(0, 99);
    if (sel < 10) clock_now = clock_now + $urandom_range(0, 40);
    if (sel < 30) k = KIND_ADD_ONCE;
    else if (sel < 50) k = KIND_ADD_REPEAT;
    else if (sel < 65) k = KIND_ERASE;
    else k = KIND_RUN;
    case ($urandom_range(0, 9))
      0: d = $urandom();
      1: d = 32'd0;
      2: d = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: d = $urandom_range(0, 60);
    endcase
    if (k == KIND_RUN) begin
      clock_now = clock_now + $urandom_range(0, 30);
      send(k, ($urandom_range(0, 19) == 0) ? $urandom() : clock_now, $urandom(), $urandom());
    end else if (k == KIND_ERASE) begin
      send(k, $urandom(), $urandom(),
           ($urandom_range(0, 4) == 0) ? $urandom() : base_id + $urandom_range(0, 40));
    end else begin
      send(k, ($urandom_range(0, 19) == 0) ? $urandom() : clock_now, d, $urandom());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    req_count = 0;
    quiet_phase = 1'b0;
    clock_now = 32'd1000;
    base_id = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(KIND_RUN, 32'd0, 32'd0, 32'd0);
    send(KIND_ERASE, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send(KIND_ADD_ONCE, 32'd0, 32'd0, 32'd0);
    send(KIND_ADD_REPEAT, 32'd5, 32'd0, 32'd0);
    send(KIND_ADD_ONCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send(KIND_ADD_REPEAT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd0);
    send(KIND_ADD_ONCE, 32'd3, 32'd3, 32'd0);
    send(KIND_ADD_ONCE, 32'd1, 32'd5, 32'd0);
    send(KIND_RUN, 32'd6, 32'd0, 32'd0);
    send(KIND_ERASE, 32'd0, 32'd0, 32'd4);
    send(KIND_ERASE, 32'd0, 32'd0, 32'd4);
    send(KIND_RUN, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send(KIND_RUN, 32'hFFFF_FFFF, 32'd0, 32'd0);
    for (int i = 0; i < 17; i++) send(KIND_ADD_ONCE, 32'd10, 32'd0, 32'd0);
    send(KIND_RUN, 32'd10, 32'd0, 32'd0);
    send(KIND_RUN, 32'hFFFF_FFFF, 32'd0, 32'd0);
    drain();
    base_id = 32'd22;
    for (int i = 0; i < 440; i++) begin
      if (i == 200) drain();
      if (i == 380) quiet_phase = 1'b1;
      if (i % 40 == 0) base_id = base_id + 20;
      send_random();
    end
    drain();
    repeat (400) @(posedge clk);
    $display("Covered %0d requests: %0d expired entries reported, %0d full-table adds.",
             req_count, expired_seen, full_seen);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    while (req_count < 60) begin
      out_ready <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
    end
    out_ready <= 1'b0;
    repeat (600) @(posedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/tpet_pkg.sv
hdl/tpet_ram.sv
hdl/timeout_pool_expiry_table_unit.sv
test/timeout_pool_expiry_table_checker.sv
test/timeout_pool_expiry_table_unit_tb.sv
